// File: rtl/core/pcpa_pkg.sv
// Shared constants, types and helpers for the per-CPU page allocator.
`default_nettype none

package pcpa_pkg;

	localparam int NUM_CPUS  = 8;
	localparam int NUM_PAGES = 4096;
	localparam int STEAL_MAX = 16;

	localparam int ADDR_W   = 32;
	localparam int PG_SHIFT = 12;
	localparam int PGNUM_W  = ADDR_W - PG_SHIFT;
	localparam int BASE_W   = PGNUM_W + 1;
	localparam int CPU_W    = $clog2(NUM_CPUS);
	localparam int PAGE_W   = $clog2(NUM_PAGES);
	localparam int LINK_W   = PAGE_W + 1;
	localparam int COUNT_W  = $clog2(2 * NUM_PAGES);
	localparam int TAKE_W   = $clog2(STEAL_MAX + 1);
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(2 * NUM_PAGES - 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_FREE = 2'd1;
	localparam logic [1:0] ST_NO_PAGE  = 2'd2;

	// commands from the controller to the datapath
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_FREE,
		CMD_SCAN_START,
		CMD_SCAN_NEXT,
		CMD_STEAL_START,
		CMD_WALK,
		CMD_STEAL_COMMIT,
		CMD_POP_READ,
		CMD_POP_COMMIT,
		CMD_FAIL,
		CMD_EMIT
	} pcpa_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic mode;
		logic me_valid;
		logic vic_has_pages;
		logic vic_valid;
		logic scan_wrap;
		logic walk_stop;
		logic out_free;
	} pcpa_stat_t;

	// cyclic successor of a CPU index
	function automatic logic [CPU_W-1:0] next_cpu(input logic [CPU_W-1:0] c);
		logic [CPU_W-1:0] n;
		if (c == CPU_W'(NUM_CPUS - 1)) begin
			n = '0;
		end else begin
			n = c + CPU_W'(1);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pcpa_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/pcpa_ctrl.sv
// Controller state machine sequencing free, scan, steal walk and pop.
`default_nettype none

module pcpa_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire pcpa_pkg::pcpa_stat_t stat,
	output pcpa_pkg::pcpa_cmd_t       cmd,
	output logic                      busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FREE,
		S_SCAN,
		S_STEAL,
		S_WALK,
		S_COMMIT,
		S_POP_RD,
		S_POP_WR,
		S_EMIT
	} state_t;

	state_t state_q;

	// issue the command for the current state
	always_comb begin
		cmd = pcpa_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) cmd = pcpa_pkg::CMD_LATCH;
			end
			S_DECODE: begin
				if (stat.mode && !stat.me_valid) cmd = pcpa_pkg::CMD_SCAN_START;
			end
			S_FREE: cmd = pcpa_pkg::CMD_FREE;
			S_SCAN: begin
				if (stat.vic_has_pages) begin
					cmd = pcpa_pkg::CMD_NONE;
				end else if (stat.scan_wrap) begin
					cmd = pcpa_pkg::CMD_FAIL;
				end else begin
					cmd = pcpa_pkg::CMD_SCAN_NEXT;
				end
			end
			S_STEAL: begin
				if (stat.vic_valid) begin
					cmd = pcpa_pkg::CMD_STEAL_START;
				end else begin
					cmd = pcpa_pkg::CMD_FAIL;
				end
			end
			S_WALK:   cmd = pcpa_pkg::CMD_WALK;
			S_COMMIT: cmd = pcpa_pkg::CMD_STEAL_COMMIT;
			S_POP_RD: cmd = pcpa_pkg::CMD_POP_READ;
			S_POP_WR: cmd = pcpa_pkg::CMD_POP_COMMIT;
			S_EMIT: begin
				if (stat.out_free) cmd = pcpa_pkg::CMD_EMIT;
			end
			default: cmd = pcpa_pkg::CMD_NONE;
		endcase
	end

	// advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (!stat.mode) begin
						state_q <= S_FREE;
					end else if (stat.me_valid) begin
						state_q <= S_POP_RD;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_FREE: state_q <= S_EMIT;
				S_SCAN: begin
					if (stat.vic_has_pages) begin
						state_q <= S_STEAL;
					end else if (stat.scan_wrap) begin
						state_q <= S_EMIT;
					end
				end
				S_STEAL: begin
					if (stat.vic_valid) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_WALK: begin
					if (stat.walk_stop) state_q <= S_COMMIT;
				end
				S_COMMIT: state_q <= S_POP_RD;
				S_POP_RD: state_q <= S_POP_WR;
				S_POP_WR: state_q <= S_EMIT;
				S_EMIT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/pcpa_dp.sv
// Datapath: list heads, counts, link table, limit registers and result word.
`default_nettype none

module pcpa_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pcpa_pkg::pcpa_cmd_t                cmd,
	output pcpa_pkg::pcpa_stat_t                    stat,
	input  wire logic                               mode,
	input  wire logic [2:0]                         cpu,
	input  wire logic [pcpa_pkg::ADDR_W-1:0]        address,
	input  wire logic                               cfg_we,
	input  wire logic [pcpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pcpa_pkg::ADDR_W-1:0]        cfg_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [pcpa_pkg::ADDR_W-1:0]        page_address,
	output logic      [1:0]                         status
);

	localparam int CPU_W   = pcpa_pkg::CPU_W;
	localparam int PAGE_W  = pcpa_pkg::PAGE_W;
	localparam int LINK_W  = pcpa_pkg::LINK_W;
	localparam int COUNT_W = pcpa_pkg::COUNT_W;
	localparam int TAKE_W  = pcpa_pkg::TAKE_W;
	localparam int PGNUM_W = pcpa_pkg::PGNUM_W;
	localparam int BASE_W  = pcpa_pkg::BASE_W;
	localparam int ADDR_W  = pcpa_pkg::ADDR_W;
	localparam int SHIFT   = pcpa_pkg::PG_SHIFT;

	// list state
	logic [PAGE_W-1:0]  head_q  [pcpa_pkg::NUM_CPUS];
	logic [COUNT_W-1:0] count_q [pcpa_pkg::NUM_CPUS];
	logic [pcpa_pkg::NUM_CPUS-1:0] valid_q;

	// limits
	logic [ADDR_W-1:0] low_q;
	logic [ADDR_W-1:0] high_q;
	logic [BASE_W-1:0] base_pg_q;

	// request and walk registers
	logic              mode_q;
	logic [CPU_W-1:0]  me_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CPU_W-1:0]  vic_q;
	logic [PAGE_W-1:0] cur_q;
	logic [PAGE_W-1:0] last_q;
	logic [PAGE_W-1:0] start_q;
	logic [TAKE_W-1:0] taken_q;
	logic [TAKE_W-1:0] want_q;

	// result
	logic [ADDR_W-1:0] res_addr_q;
	logic [1:0]        res_status_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] page_address_q;
	logic [1:0]        status_q;

	// link table port
	logic              ram_we;
	logic [PAGE_W-1:0] ram_waddr;
	logic [LINK_W-1:0] ram_wdata;
	logic [PAGE_W-1:0] ram_raddr;
	logic [LINK_W-1:0] link;

	// decoded link
	logic              link_end;
	logic [LINK_W-1:0] link_m1;
	logic [PAGE_W-1:0] link_next;
	logic [TAKE_W-1:0] taken_inc;

	// free checks
	logic               free_ok;
	logic [PGNUM_W-1:0] free_idx;
	logic [PAGE_W-1:0]  free_page;

	// steal setup and pop result
	logic [TAKE_W-1:0]  want_new;
	logic [PAGE_W-1:0]  me_head;
	logic [PGNUM_W-1:0] pop_pg;

	logic [CPU_W-1:0] me_in;
	logic             out_free;

	pcpa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(pcpa_pkg::NUM_PAGES)
	) u_link (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(link)
	);

	// fold the CPU number onto the list count
	assign me_in = CPU_W'(32'(cpu) % pcpa_pkg::NUM_CPUS);

	// decode the link word read back from the table
	assign link_end  = (link == '0) || (link > LINK_W'(pcpa_pkg::NUM_PAGES));
	assign link_m1   = link - LINK_W'(1);
	assign link_next = link_m1[PAGE_W-1:0];
	assign taken_inc = taken_q + TAKE_W'(1);

	// check a freed address and find its page index
	assign free_idx  = addr_q[ADDR_W-1:SHIFT] - base_pg_q[PGNUM_W-1:0];
	assign free_page = free_idx[PAGE_W-1:0];
	assign free_ok   = (addr_q[SHIFT-1:0] == '0) && (addr_q >= low_q) && (addr_q < high_q)
		&& ({1'b0, free_idx} < BASE_W'(pcpa_pkg::NUM_PAGES));

	// clamp the steal batch
	assign want_new = (count_q[vic_q] > COUNT_W'(pcpa_pkg::STEAL_MAX))
		? TAKE_W'(pcpa_pkg::STEAL_MAX) : count_q[vic_q][TAKE_W-1:0];

	assign me_head = head_q[me_q];
	assign pop_pg  = base_pg_q[PGNUM_W-1:0] + PGNUM_W'(me_head);

	assign out_free = !out_valid_q || !out_stall;

	// drive the link table
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = last_q;
		ram_wdata = '0;
		ram_raddr = cur_q;
		unique case (cmd)
			pcpa_pkg::CMD_FREE: begin
				ram_we    = free_ok;
				ram_waddr = free_page;
				ram_wdata = valid_q[me_q] ? ({1'b0, me_head} + LINK_W'(1)) : '0;
			end
			pcpa_pkg::CMD_STEAL_START: ram_raddr = head_q[vic_q];
			pcpa_pkg::CMD_WALK:        ram_raddr = link_next;
			pcpa_pkg::CMD_STEAL_COMMIT: begin
				ram_we    = 1'b1;
				ram_waddr = last_q;
				ram_wdata = '0;
			end
			pcpa_pkg::CMD_POP_READ:    ram_raddr = me_head;
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// list state, limits and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcpa_pkg::NUM_CPUS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			valid_q     <= '0;
			low_q       <= '0;
			high_q      <= ADDR_W'(32'd16777216);
			base_pg_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// take configuration words
			if (cfg_we) begin
				if (cfg_index == pcpa_pkg::REG_LOW_LIMIT) begin
					low_q     <= cfg_data;
					base_pg_q <= BASE_W'(({1'b0, cfg_data} + 33'd4095) >> SHIFT);
				end else if (cfg_index == pcpa_pkg::REG_HIGH_LIMIT) begin
					high_q <= cfg_data;
				end
			end

			unique case (cmd)
				pcpa_pkg::CMD_FREE: begin
					if (free_ok) begin
						head_q[me_q]  <= free_page;
						valid_q[me_q] <= 1'b1;
						if (count_q[me_q] != pcpa_pkg::COUNT_MAX) begin
							count_q[me_q] <= count_q[me_q] + COUNT_W'(1);
						end
					end
				end
				pcpa_pkg::CMD_WALK: begin
					if (link_end) begin
						head_q[vic_q]  <= '0;
						valid_q[vic_q] <= 1'b0;
					end else begin
						head_q[vic_q] <= link_next;
					end
				end
				pcpa_pkg::CMD_STEAL_COMMIT: begin
					head_q[me_q]   <= start_q;
					valid_q[me_q]  <= 1'b1;
					count_q[me_q]  <= COUNT_W'(taken_q);
					count_q[vic_q] <= count_q[vic_q] - COUNT_W'(taken_q);
				end
				pcpa_pkg::CMD_POP_COMMIT: begin
					if (link_end) begin
						head_q[me_q]  <= '0;
						valid_q[me_q] <= 1'b0;
					end else begin
						head_q[me_q] <= link_next;
					end
					if (count_q[me_q] != '0) begin
						count_q[me_q] <= count_q[me_q] - COUNT_W'(1);
					end
				end
				default: begin
				end
			endcase

			// present or drop the result word
			if (cmd == pcpa_pkg::CMD_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, walk and result registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			pcpa_pkg::CMD_LATCH: begin
				mode_q <= mode;
				me_q   <= me_in;
				addr_q <= address;
			end
			pcpa_pkg::CMD_FREE: begin
				res_addr_q   <= '0;
				res_status_q <= free_ok ? pcpa_pkg::ST_OK : pcpa_pkg::ST_BAD_FREE;
			end
			pcpa_pkg::CMD_SCAN_START: vic_q <= pcpa_pkg::next_cpu(me_q);
			pcpa_pkg::CMD_SCAN_NEXT:  vic_q <= pcpa_pkg::next_cpu(vic_q);
			pcpa_pkg::CMD_STEAL_START: begin
				want_q  <= want_new;
				start_q <= head_q[vic_q];
				cur_q   <= head_q[vic_q];
				taken_q <= '0;
			end
			pcpa_pkg::CMD_WALK: begin
				last_q  <= cur_q;
				cur_q   <= link_next;
				taken_q <= taken_inc;
			end
			pcpa_pkg::CMD_POP_COMMIT: begin
				res_addr_q   <= {pop_pg, {SHIFT{1'b0}}};
				res_status_q <= pcpa_pkg::ST_OK;
			end
			pcpa_pkg::CMD_FAIL: begin
				res_addr_q   <= '0;
				res_status_q <= pcpa_pkg::ST_NO_PAGE;
			end
			pcpa_pkg::CMD_EMIT: begin
				page_address_q <= res_addr_q;
				status_q       <= res_status_q;
			end
			default: begin
			end
		endcase
	end

	// status to the controller
	always_comb begin
		stat.mode          = mode_q;
		stat.me_valid      = valid_q[me_q];
		stat.vic_has_pages = (count_q[vic_q] != '0);
		stat.vic_valid     = valid_q[vic_q];
		stat.scan_wrap     = (pcpa_pkg::next_cpu(vic_q) == me_q);
		stat.walk_stop     = link_end || (taken_inc == want_q);
		stat.out_free      = out_free;
	end

	assign out_valid    = out_valid_q;
	assign page_address = page_address_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// File: rtl/core/per_cpu_page_allocator_steal_top.sv
// Top level of the per-CPU page allocator with stealing.
//
// Input channel (in_valid / in_stall): one word holds mode, cpu and address.
// mode 0 frees the page at address onto the list of cpu; mode 1 takes a page
// for cpu, stealing up to 16 pages from the next CPU list with a nonzero
// count when its own list is empty. Output channel (out_valid / out_stall):
// one word per request with page_address and status (0 ok, 1 rejected free,
// 2 no page). Configuration: cfg_we writes cfg_data to low_limit (index 0)
// or high_limit (index 1); the user must write it only while the block is
// idle, and the block itself does not enforce this. One request is handled
// at a time. The steal walk follows one link per cycle through the single
// read port of the link table. The result sits in an output register: the
// next request is accepted while it waits. A stalled receiver holds the word,
// and a following result waits in its final state until the register frees.
// Reset empties every list, clears the counts and sets the limits to 0 and
// 16 MiB; the link table has no reset and is only read where written.
`default_nettype none

module per_cpu_page_allocator_steal_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               mode,
	input  wire logic [2:0]                         cpu,
	input  wire logic [pcpa_pkg::ADDR_W-1:0]        address,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [pcpa_pkg::ADDR_W-1:0]        page_address,
	output logic      [1:0]                         status,
	input  wire logic                               cfg_we,
	input  wire logic [pcpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pcpa_pkg::ADDR_W-1:0]        cfg_data
);

	pcpa_pkg::pcpa_cmd_t  cmd;
	pcpa_pkg::pcpa_stat_t stat;
	logic                 busy;

	pcpa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	pcpa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.cpu         (cpu),
		.address     (address),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.page_address(page_address),
		.status      (status)
	);

	// refuse new words while a request is in progress
	assign in_stall = busy;

endmodule

`default_nettype wire

// File: verif/per_cpu_page_allocator_steal_tb.sv
// Self-checking testbench for the per-CPU page allocator with stealing.
`timescale 1ns / 100ps

module testbench;

	localparam int ADDR_W    = pcpa_pkg::ADDR_W;
	localparam int PG_SHIFT  = pcpa_pkg::PG_SHIFT;
	localparam int PAGE_W    = pcpa_pkg::PAGE_W;
	localparam int LINK_W    = pcpa_pkg::LINK_W;
	localparam int COUNT_W   = pcpa_pkg::COUNT_W;
	localparam int CFG_IDX_W = pcpa_pkg::CFG_IDX_W;
	localparam int NUM_CPUS  = pcpa_pkg::NUM_CPUS;
	localparam int NUM_PAGES = pcpa_pkg::NUM_PAGES;
	localparam int STEAL_MAX = pcpa_pkg::STEAL_MAX;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int IDLE_PCT = 33;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER_WORDS = 150;
	localparam int SETTLE_CYCLES = 40;
	localparam int STEADY_FREES = 200;

	typedef struct packed {
		logic [ADDR_W-1:0] page;
		logic [1:0]        status;
	} page_reply_t;

	typedef struct packed {
		logic              mode;
		logic [2:0]        cpu;
		logic [ADDR_W-1:0] addr;
		bit                fixed;
		logic [ADDR_W-1:0] page;
		logic [1:0]        status;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [2:0] cpu = 3'd0;
	logic [ADDR_W-1:0] address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ADDR_W-1:0] page_address;
	logic [1:0] status;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0] cfg_data = '0;

	// allocator state mirrored by the testbench
	logic [ADDR_W-1:0]  low_bound = 32'h0000_0000;
	logic [ADDR_W-1:0]  high_bound = 32'h0100_0000;
	logic [PAGE_W-1:0]  list_top [NUM_CPUS];
	bit                 list_live [NUM_CPUS];
	logic [COUNT_W-1:0] list_len [NUM_CPUS];
	logic [LINK_W-1:0]  successor [NUM_PAGES];

	page_reply_t pending_replies [$];
	stim_row_t   warmup_rows [$];
	page_reply_t oldest_reply;
	int mismatches = 0;
	int words_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit steady = 1'b0;
	int cycles = 0;

	per_cpu_page_allocator_steal_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.cpu(cpu),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_address(page_address),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// first tracked page: low bound rounded up, may reach 2^32
	function automatic logic [ADDR_W:0] page_base();
		return ({1'b0, low_bound} + 33'h0_0000_0FFF) & ~33'h0_0000_0FFF;
	endfunction

	// apply one request to the mirrored lists and work out the reply word
	task automatic apply_page_request(input logic m, input logic [2:0] c,
		input logic [ADDR_W-1:0] a, output page_reply_t r);
		logic [ADDR_W:0] base;
		logic [ADDR_W:0] offs;
		logic [ADDR_W:0] full;
		logic [PAGE_W-1:0] idx;
		logic [PAGE_W-1:0] start;
		logic [PAGE_W-1:0] last;
		logic [PAGE_W-1:0] top;
		logic [LINK_W-1:0] nx;
		logic [COUNT_W-1:0] want;
		logic [COUNT_W-1:0] taken;
		logic [2:0] victim;
		bit start_live;
		bit found;
		base = page_base();
		r.page = '0;
		r.status = pcpa_pkg::ST_OK;
		if (m == 1'b0) begin
			// free: check alignment, limits and store size, then push
			offs = {1'b0, a} - base;
			if (a[11:0] != 12'h000 || a < low_bound || a >= high_bound) begin
				r.status = pcpa_pkg::ST_BAD_FREE;
			end else if (offs[ADDR_W:PG_SHIFT] >= 21'(NUM_PAGES)) begin
				r.status = pcpa_pkg::ST_BAD_FREE;
			end else begin
				idx = offs[PG_SHIFT+PAGE_W-1:PG_SHIFT];
				successor[idx] = list_live[c] ? {1'b0, list_top[c]} + 13'd1 : '0;
				list_top[c] = idx;
				list_live[c] = 1'b1;
				if (list_len[c] < pcpa_pkg::COUNT_MAX) begin
					list_len[c] = list_len[c] + COUNT_W'(1);
				end
			end
		end else begin
			// own list empty: scan the others and take from the first with a count
			if (!list_live[c]) begin
				victim = c + 3'd1;
				found = 1'b0;
				while (victim != c && !found) begin
					if (list_len[victim] != '0) begin
						found = 1'b1;
						want = (list_len[victim] > COUNT_W'(STEAL_MAX)) ?
							COUNT_W'(STEAL_MAX) : list_len[victim];
						taken = '0;
						last = '0;
						start = list_top[victim];
						start_live = list_live[victim];
						while (taken < want && list_live[victim]) begin
							last = list_top[victim];
							nx = successor[last];
							if (nx == '0 || nx > LINK_W'(NUM_PAGES)) begin
								list_live[victim] = 1'b0;
								list_top[victim] = '0;
							end else begin
								list_top[victim] = PAGE_W'(nx - 13'd1);
							end
							taken = taken + COUNT_W'(1);
						end
						if (taken != '0) begin
							successor[last] = '0;
							list_top[c] = start;
							list_live[c] = start_live;
							list_len[c] = taken;
							list_len[victim] = list_len[victim] - taken;
						end
					end else begin
						victim = victim + 3'd1;
					end
				end
			end
			// pop the top page, if any
			if (list_live[c]) begin
				top = list_top[c];
				nx = successor[top];
				if (nx == '0 || nx > LINK_W'(NUM_PAGES)) begin
					list_live[c] = 1'b0;
					list_top[c] = '0;
				end else begin
					list_top[c] = PAGE_W'(nx - 13'd1);
				end
				if (list_len[c] != '0) begin
					list_len[c] = list_len[c] - COUNT_W'(1);
				end
				full = base + {9'b0, top, 12'h000};
				r.page = full[ADDR_W-1:0];
			end else begin
				r.status = pcpa_pkg::ST_NO_PAGE;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
		input logic [ADDR_W-1:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
		mismatches++;
	endtask

	// offer one word, idling at random first, and log its reply once taken
	task automatic send_request(input logic m, input logic [2:0] c,
		input logic [ADDR_W-1:0] a, input bit fixed, input logic [ADDR_W-1:0] pg,
		input logic [1:0] st);
		page_reply_t r;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		cpu <= c;
		address <= a;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		apply_page_request(m, c, a, r);
		if (fixed) begin
			r.page = pg;
			r.status = st;
		end
		pending_replies.push_back(r);
	endtask

	// mostly pages near the base, plus raw, boundary and misaligned addresses
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W:0] base;
		logic [ADDR_W-1:0] a;
		int k;
		base = page_base();
		k = $urandom_range(0, 99);
		if (k < 40) begin
			a = 32'(base + {9'b0, 12'($urandom_range(0, 15)), 12'h000});
		end else if (k < 65) begin
			a = 32'(base + {9'b0, 12'($urandom_range(0, 4095)), 12'h000});
		end else if (k < 75) begin
			a = $urandom;
		end else if (k < 85) begin
			a = {high_bound[31:12], 12'h000} - (32'($urandom_range(0, 1)) << 12);
		end else if (k < 92) begin
			a = low_bound;
		end else begin
			a = 32'(base) | 32'($urandom_range(1, 4095));
		end
		return a;
	endfunction

	task automatic run_mix(input int n, input int alloc_pct);
		int k;
		logic m;
		logic [2:0] c;
		for (k = 0; k < n; k++) begin
			m = ($urandom_range(0, 99) < alloc_pct);
			c = 3'($urandom_range(0, 7));
			send_request(m, c, pick_address(), 1'b0, '0, pcpa_pkg::ST_OK);
		end
	endtask

	// drop valid and wait until every reply is back
	task automatic wait_for_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == pcpa_pkg::REG_LOW_LIMIT) begin
			low_bound = v;
		end else begin
			high_bound = v;
		end
	endtask

	task automatic add_row(input logic m, input logic [2:0] c, input logic [ADDR_W-1:0] a,
		input bit fixed, input logic [ADDR_W-1:0] pg, input logic [1:0] st);
		stim_row_t row;
		row.mode = m;
		row.cpu = c;
		row.addr = a;
		row.fixed = fixed;
		row.page = pg;
		row.status = st;
		warmup_rows.push_back(row);
	endtask

	// receiver: random stall, one long hold-off, none while steady
	always @(negedge clk) begin
		if (!hold_done && words_seen >= HOLD_AFTER_WORDS) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// compare each reply word with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			words_seen = words_seen + 1;
			if (pending_replies.size() == 0) begin
				report_mismatch("word with nothing pending", page_address, '0);
			end else begin
				oldest_reply = pending_replies.pop_front();
				if (page_address !== oldest_reply.page) begin
					report_mismatch("page_address", page_address, oldest_reply.page);
				end
				if (status !== oldest_reply.status) begin
					report_mismatch("status", {30'b0, status}, {30'b0, oldest_reply.status});
				end
			end
		end
	end

	// hard stop on a hung run
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int i;
		stim_row_t row;
		for (i = 0; i < NUM_CPUS; i++) begin
			list_top[i] = '0;
			list_live[i] = 1'b0;
			list_len[i] = '0;
		end
		for (i = 0; i < NUM_PAGES; i++) begin
			successor[i] = '0;
		end

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		set_limit(pcpa_pkg::REG_LOW_LIMIT, 32'h0000_0000);
		set_limit(pcpa_pkg::REG_HIGH_LIMIT, 32'h0100_0000);

		// empty lists, rejected frees, plain push and pop
		add_row(1'b1, 3'd0, 32'hFFFF_FFFF, 1'b1, 32'h0, pcpa_pkg::ST_NO_PAGE);
		add_row(1'b0, 3'd0, 32'h0000_0001, 1'b1, 32'h0, pcpa_pkg::ST_BAD_FREE);
		add_row(1'b0, 3'd0, 32'h0000_0FFF, 1'b1, 32'h0, pcpa_pkg::ST_BAD_FREE);
		add_row(1'b0, 3'd0, 32'h0100_0000, 1'b1, 32'h0, pcpa_pkg::ST_BAD_FREE);
		add_row(1'b0, 3'd0, 32'hFFFF_F000, 1'b1, 32'h0, pcpa_pkg::ST_BAD_FREE);
		add_row(1'b0, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'h0, pcpa_pkg::ST_BAD_FREE);
		add_row(1'b0, 3'd0, 32'h0000_0000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd0, 32'h0000_0000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		// fill one list, then steal it from the far end of the ring
		add_row(1'b0, 3'd3, 32'h00FF_F000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b0, 3'd3, 32'h0000_1000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b0, 3'd3, 32'h0000_2000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd7, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd7, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd3, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd3, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		// double free and a page shared by two lists
		add_row(1'b0, 3'd1, 32'h0000_5000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b0, 3'd1, 32'h0000_5000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b0, 3'd2, 32'h0000_5000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd1, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd2, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		// victim with a count but no pages ends the scan
		add_row(1'b0, 3'd4, 32'h0000_9000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd0, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd4, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b0, 3'd6, 32'h00FF_F000, 1'b1, 32'h0, pcpa_pkg::ST_OK);
		add_row(1'b1, 3'd5, 32'h0000_0000, 1'b0, 32'h0, pcpa_pkg::ST_OK);
		foreach (warmup_rows[r]) begin
			row = warmup_rows[r];
			send_request(row.mode, row.cpu, row.addr, row.fixed, row.page, row.status);
		end

		run_mix(500, 50);

		// back-to-back frees onto one list, no idling on either side
		steady = 1'b1;
		for (i = 0; i < STEADY_FREES; i++) begin
			send_request(1'b0, 3'd5, {8'h00, 12'($urandom_range(0, 4095)), 12'h000},
				1'b0, '0, pcpa_pkg::ST_OK);
		end
		steady = 1'b0;
		run_mix(120, 70);

		wait_for_idle();
		set_limit(pcpa_pkg::REG_LOW_LIMIT, 32'h0000_0001);
		set_limit(pcpa_pkg::REG_HIGH_LIMIT, 32'hFFFF_FFFF);
		run_mix(250, 45);

		wait_for_idle();
		set_limit(pcpa_pkg::REG_LOW_LIMIT, 32'h8000_0800);
		set_limit(pcpa_pkg::REG_HIGH_LIMIT, 32'h8080_0000);
		run_mix(250, 50);

		// base past the top of the address space: every free is rejected
		wait_for_idle();
		set_limit(pcpa_pkg::REG_LOW_LIMIT, 32'hFFFF_FFFF);
		set_limit(pcpa_pkg::REG_HIGH_LIMIT, 32'hFFFF_FFFF);
		run_mix(100, 60);

		wait_for_idle();
		set_limit(pcpa_pkg::REG_LOW_LIMIT, 32'h0000_0000);
		set_limit(pcpa_pkg::REG_HIGH_LIMIT, 32'h0000_0000);
		run_mix(60, 50);

		wait_for_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/pcpa_pkg.sv
rtl/core/pcpa_ram.sv
rtl/core/pcpa_ctrl.sv
rtl/core/pcpa_dp.sv
rtl/core/per_cpu_page_allocator_steal_top.sv
verif/per_cpu_page_allocator_steal_tb.sv
